[rtl/core/gis_pkg.sv]
// shared types, codes and the q16 reciprocal weight function for the smoothing block
package gis_pkg;

  localparam int PIX_W = 8;
  localparam int WT_W  = 18;
  localparam int CFG_W = 16;

  // weight for a zero difference, 2.0 in q16
  localparam logic [WT_W-1:0] WT_ZERO = 18'd131072;

  // item kinds
  localparam logic FUNC_PUSH  = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  // register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_HALF_X       = 2'd2;
  localparam logic [1:0] REG_HALF_Y       = 2'd3;

  typedef struct packed {
    logic             func;
    logic [PIX_W-1:0] pixel;
  } gis_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic             end_of_line;
    logic             end_of_frame;
    logic             rejected;
    logic             last_of_run;
  } gis_out_t;

  // q16 reciprocal rounded to nearest, by long division over the numerator bits
  function automatic logic [WT_W-1:0] recip_q16(input logic [PIX_W-1:0] d);
    logic [16:0]      num;
    logic [PIX_W:0]   rem;
    logic [WT_W-1:0]  q;
    num = 17'd65536 + 17'(d >> 1);
    rem = '0;
    q   = '0;
    if (d == '0) begin
      q = WT_ZERO;
    end else begin
      for (int i = 16; i >= 0; i--) begin
        rem = {rem[PIX_W-1:0], num[i]};
        if (rem >= {1'b0, d}) begin
          rem  = rem - {1'b0, d};
          q[i] = 1'b1;
        end
      end
    end
    return q;
  endfunction

endpackage

[rtl/core/gis_ram.sv]
// generic single port ram with registered read
module gis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 7168
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write or registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/gis_mac.sv]
// weight lookup and accumulation of weight and weighted neighbor sums
module gis_mac
  import gis_pkg::*;
#(
  parameter int SW_W  = 23,
  parameter int SWP_W = 31
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr,
  input  logic             en,
  input  logic [PIX_W-1:0] centre,
  input  logic [PIX_W-1:0] nbr,
  output logic [SW_W-1:0]  sw,
  output logic [SWP_W-1:0] swp
);

  logic [WT_W-1:0]  wt_lut [256];
  logic [PIX_W-1:0] diff;
  logic [WT_W-1:0]  wt;
  logic [SW_W-1:0]  sw_r, sw_nxt;
  logic [SWP_W-1:0] swp_r, swp_nxt;

  // constant reciprocal table
  for (genvar g = 0; g < 256; g++) begin : g_lut
    assign wt_lut[g] = recip_q16(PIX_W'(g));
  end

  // absolute difference and weight
  always_comb begin
    diff = (nbr >= centre) ? (nbr - centre) : (centre - nbr);
    wt   = wt_lut[diff];
  end

  // accumulate
  always_comb begin
    sw_nxt  = sw_r;
    swp_nxt = swp_r;
    if (clr) begin
      sw_nxt  = '0;
      swp_nxt = '0;
    end else if (en) begin
      sw_nxt  = sw_r + SW_W'(wt);
      swp_nxt = swp_r + SWP_W'(wt) * SWP_W'(nbr);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r  <= '0;
      swp_r <= '0;
    end else begin
      sw_r  <= sw_nxt;
      swp_r <= swp_nxt;
    end
  end

  assign sw  = sw_r;
  assign swp = swp_r;

endmodule

[rtl/core/gis_div.sv]
// restoring divider, one quotient bit per cycle, quotient known to fit a pixel
module gis_div
  import gis_pkg::*;
#(
  parameter int NUM_W = 32,
  parameter int DEN_W = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [PIX_W-1:0] q
);

  localparam int DSH_W = DEN_W + PIX_W - 1;
  localparam int CNT_W = $clog2(PIX_W + 1);

  logic [NUM_W-1:0] rem_r, rem_nxt;
  logic [DSH_W-1:0] dsh_r, dsh_nxt;
  logic [PIX_W-1:0] q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [NUM_W-1:0] dsh_ext;

  // one compare and subtract per step
  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    dsh_ext  = NUM_W'(dsh_r);
    if (start) begin
      rem_nxt  = num;
      dsh_nxt  = {den, {(PIX_W-1){1'b0}}};
      q_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= dsh_ext) begin
        rem_nxt = rem_r - dsh_ext;
        q_nxt   = {q_r[PIX_W-2:0], 1'b1};
      end else begin
        q_nxt   = {q_r[PIX_W-2:0], 1'b0};
      end
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(PIX_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

[rtl/core/gradient_inverse_smoothing.sv]
// gradient inverse weighted smoothing of a raster pixel stream, top level and sequencer
//
//   channel  direction  handshake         payload
//   in_      input      valid / ready     gis_in_t  (func, pixel)
//   out_     output     valid / ready     gis_out_t (pixel, eol, eof, rejected, last)
//   cfg_     input      write enable      index, 16 bit data
//
// a push stores its pixel and then, for each output it releases, reads the centre pixel,
// walks the clipped window with one ring read per neighbor through the single ram port,
// does one multiply, then 8 divider steps. a drain is one output the same way.
// the block takes no beat while an item is at work; a stalled result port holds the
// sequencer in its emit step. reset is synchronous, active low, and needs no clearing pass.
module gradient_inverse_smoothing
  import gis_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HALF_X = 3,
  parameter int MAX_HALF_Y = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  gis_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output gis_out_t         out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int RING_ROWS   = 2 * MAX_HALF_Y + 1;
  localparam int RING_DEPTH  = RING_ROWS * MAX_WIDTH;
  localparam int ADDR_W      = $clog2(RING_DEPTH);
  localparam int SLOT_W      = $clog2(RING_ROWS);
  localparam int SL1_W       = SLOT_W + 1;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int WCNT_W      = $clog2(MAX_WIDTH + 1);
  localparam int XS_W        = $clog2(MAX_WIDTH + MAX_HALF_X);
  localparam int HX_W        = $clog2(MAX_HALF_X + 1);
  localparam int HY_W        = $clog2(MAX_HALF_Y + 1);
  localparam int MAX_RESULTS = MAX_HALF_X + 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int NBRS        = (2 * MAX_HALF_X + 1) * (2 * MAX_HALF_Y + 1) - 1;
  localparam int SW_W        = $clog2(NBRS * 131072 + 1);
  localparam int SWP_W       = SW_W + PIX_W;
  localparam int NUM_W       = SW_W + PIX_W + 1;
  localparam int DEN_W       = SW_W + 1;

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_CENTRE = 4'd2;
  localparam logic [3:0] S_CWAIT  = 4'd3;
  localparam logic [3:0] S_WALK   = 4'd4;
  localparam logic [3:0] S_MULT   = 4'd5;
  localparam logic [3:0] S_DLOAD  = 4'd6;
  localparam logic [3:0] S_DIV    = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic [10:0]       cfg_w_r, cfg_w_nxt;
  logic [15:0]       cfg_h_r, cfg_h_nxt;
  logic [1:0]        cfg_hx_r, cfg_hx_nxt;
  logic [1:0]        cfg_hy_r, cfg_hy_nxt;
  logic [COL_W-1:0]  in_col_r, in_col_nxt;
  logic [15:0]       in_row_r, in_row_nxt;
  logic [SLOT_W-1:0] in_slot_r, in_slot_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [15:0]       out_row_r, out_row_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic              draining_r, draining_nxt;
  logic [COL_W-1:0]  pos_col_r, pos_col_nxt;
  logic [15:0]       pos_row_r, pos_row_nxt;
  logic              frame_pend_r, frame_pend_nxt;
  logic              push_mode_r, push_mode_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic              hold_r, hold_nxt;
  logic              last_r, last_nxt;
  gis_out_t          res_r, res_nxt;
  logic [PIX_W-1:0]  c_r, c_nxt;
  logic [COL_W-1:0]  wx_r, wx_nxt;
  logic [15:0]       wy_r, wy_nxt;
  logic [SLOT_W-1:0] wslot_r, wslot_nxt;
  logic [COL_W-1:0]  x0_r, x0_nxt;
  logic [COL_W-1:0]  x1_r, x1_nxt;
  logic [15:0]       y1_r, y1_nxt;
  logic              walk_done_r, walk_done_nxt;
  logic              pend_r, pend_nxt;
  logic [NUM_W-1:0]  prod_r, prod_nxt;
  logic              out_valid_r, out_valid_nxt;
  gis_out_t          out_data_r, out_data_nxt;

  // effective register values
  logic [WCNT_W-1:0] w_eff;
  logic [15:0]       h_eff;
  logic [HX_W-1:0]   hx_eff;
  logic [HY_W-1:0]   hy_eff;
  logic [COL_W-1:0]  wm1;
  logic [15:0]       hm1;

  // window geometry of the current output
  logic [XS_W-1:0]   cx;
  logic [COL_W-1:0]  x0_c, x1_c;
  logic [16:0]       ry;
  logic [15:0]       y0_c, y1_c;
  logic [HY_W-1:0]   dy;
  logic [SL1_W-1:0]  slot_tmp;
  logic [SLOT_W-1:0] slot0_c;
  logic              ready_ok;
  logic              more;

  // shared units
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [PIX_W-1:0]  ram_wdata, ram_rdata;
  logic              mac_clr, mac_en;
  logic [SW_W-1:0]   mac_sw;
  logic [SWP_W-1:0]  mac_swp;
  logic              div_start, div_done;
  logic [PIX_W-1:0]  div_q;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic [PIX_W:0]    c_inc;
  logic              commit;
  logic [PIX_W-1:0]  commit_pix;
  logic              eol, eof;
  logic              finish;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [SLOT_W-1:0] slot,
                                                input logic [COL_W-1:0] col);
    return ADDR_W'(slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
  endfunction

  // saturate registers into range
  always_comb begin
    if (cfg_w_r == '0) begin
      w_eff = WCNT_W'(1);
    end else if (32'(cfg_w_r) > MAX_WIDTH) begin
      w_eff = WCNT_W'(MAX_WIDTH);
    end else begin
      w_eff = WCNT_W'(cfg_w_r);
    end
    h_eff = (cfg_h_r == '0) ? 16'd1 : cfg_h_r;
    if (cfg_hx_r == '0) begin
      hx_eff = HX_W'(1);
    end else if (32'(cfg_hx_r) > MAX_HALF_X) begin
      hx_eff = HX_W'(MAX_HALF_X);
    end else begin
      hx_eff = HX_W'(cfg_hx_r);
    end
    if (cfg_hy_r == '0) begin
      hy_eff = HY_W'(1);
    end else if (32'(cfg_hy_r) > MAX_HALF_Y) begin
      hy_eff = HY_W'(MAX_HALF_Y);
    end else begin
      hy_eff = HY_W'(cfg_hy_r);
    end
    wm1 = COL_W'(w_eff - WCNT_W'(1));
    hm1 = h_eff - 16'd1;
  end

  // clipped window bounds, first ring slot and readiness of the next output
  always_comb begin
    cx   = XS_W'(out_col_r) + XS_W'(hx_eff);
    x1_c = (cx < XS_W'(w_eff)) ? COL_W'(cx) : wm1;
    x0_c = (XS_W'(out_col_r) > XS_W'(hx_eff)) ? COL_W'(XS_W'(out_col_r) - XS_W'(hx_eff))
                                              : '0;
    ry   = 17'(out_row_r) + 17'(hy_eff);
    y1_c = (ry < {1'b0, h_eff}) ? ry[15:0] : hm1;
    y0_c = (out_row_r > 16'(hy_eff)) ? (out_row_r - 16'(hy_eff)) : '0;
    dy   = HY_W'(out_row_r - y0_c);
    slot_tmp = SL1_W'(out_slot_r) + SL1_W'(RING_ROWS) - SL1_W'(dy);
    if (slot_tmp >= SL1_W'(RING_ROWS)) begin
      slot_tmp = slot_tmp - SL1_W'(RING_ROWS);
    end
    slot0_c  = SLOT_W'(slot_tmp);
    ready_ok = (ry < {1'b0, h_eff}) &&
               ((ry < {1'b0, pos_row_r}) || ((ry == {1'b0, pos_row_r}) && (x1_c <= pos_col_r)));
    more     = push_mode_r && (n_r < CNT_W'(MAX_RESULTS)) && ready_ok;
    eol      = (out_col_r == wm1);
    eof      = eol && (out_row_r == hm1);
    c_inc    = {1'b0, c_r} + (PIX_W+1)'(1);
    div_num  = NUM_W'(mac_swp) + prod_r;
    div_den  = {mac_sw, 1'b0};
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cfg_w_nxt      = cfg_w_r;
    cfg_h_nxt      = cfg_h_r;
    cfg_hx_nxt     = cfg_hx_r;
    cfg_hy_nxt     = cfg_hy_r;
    in_col_nxt     = in_col_r;
    in_row_nxt     = in_row_r;
    in_slot_nxt    = in_slot_r;
    out_col_nxt    = out_col_r;
    out_row_nxt    = out_row_r;
    out_slot_nxt   = out_slot_r;
    draining_nxt   = draining_r;
    pos_col_nxt    = pos_col_r;
    pos_row_nxt    = pos_row_r;
    frame_pend_nxt = frame_pend_r;
    push_mode_nxt  = push_mode_r;
    n_nxt          = n_r;
    hold_nxt       = hold_r;
    last_nxt       = last_r;
    res_nxt        = res_r;
    c_nxt          = c_r;
    wx_nxt         = wx_r;
    wy_nxt         = wy_r;
    wslot_nxt      = wslot_r;
    x0_nxt         = x0_r;
    x1_nxt         = x1_r;
    y1_nxt         = y1_r;
    walk_done_nxt  = walk_done_r;
    pend_nxt       = pend_r;
    prod_nxt       = prod_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_addr       = addr_of(in_slot_r, in_col_r);
    ram_wdata      = in_data.pixel;
    mac_clr        = 1'b0;
    mac_en         = 1'b0;
    div_start      = 1'b0;
    commit         = 1'b0;
    commit_pix     = c_r;
    finish         = 1'b0;

    // result register drains on its own
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.func == FUNC_PUSH) begin
            if (draining_r) begin
              res_nxt          = '0;
              res_nxt.rejected = 1'b1;
              frame_pend_nxt   = 1'b0;
              push_mode_nxt    = 1'b0;
              last_nxt         = 1'b1;
              hold_nxt         = 1'b1;
              state_nxt        = S_EMIT;
            end else begin
              // store the pixel and step the input position
              ram_we         = 1'b1;
              pos_col_nxt    = in_col_r;
              pos_row_nxt    = in_row_r;
              frame_pend_nxt = 1'b0;
              push_mode_nxt  = 1'b1;
              n_nxt          = '0;
              hold_nxt       = 1'b0;
              if (in_col_r == wm1) begin
                in_col_nxt = '0;
                if (in_row_r == hm1) begin
                  in_row_nxt     = '0;
                  in_slot_nxt    = '0;
                  frame_pend_nxt = 1'b1;
                end else begin
                  in_row_nxt  = in_row_r + 16'd1;
                  in_slot_nxt = (in_slot_r == SLOT_W'(RING_ROWS - 1)) ? '0
                                                                      : in_slot_r + 1'b1;
                end
              end else begin
                in_col_nxt = in_col_r + 1'b1;
              end
              state_nxt = S_CHECK;
            end
          end else if (draining_r) begin
            push_mode_nxt  = 1'b0;
            frame_pend_nxt = 1'b0;
            n_nxt          = '0;
            hold_nxt       = 1'b0;
            state_nxt      = S_CENTRE;
          end
        end
      end
      S_CHECK: begin
        if (hold_r) begin
          last_nxt  = !more;
          state_nxt = S_EMIT;
        end else if (more) begin
          state_nxt = S_CENTRE;
        end else begin
          finish    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt             = res_r;
          out_data_nxt.last_of_run = last_r;
          hold_nxt                 = 1'b0;
          if (last_r) begin
            finish    = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_CENTRE;
          end
        end
      end
      S_CENTRE: begin
        // read the centre pixel and set up the window walk
        ram_addr      = addr_of(out_slot_r, out_col_r);
        mac_clr       = 1'b1;
        wx_nxt        = x0_c;
        wy_nxt        = y0_c;
        wslot_nxt     = slot0_c;
        x0_nxt        = x0_c;
        x1_nxt        = x1_c;
        y1_nxt        = y1_c;
        walk_done_nxt = 1'b0;
        pend_nxt      = 1'b0;
        state_nxt     = S_CWAIT;
      end
      S_CWAIT: begin
        c_nxt     = ram_rdata;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        // issue one neighbor read a cycle, accumulate the one read before
        mac_en   = pend_r;
        ram_addr = addr_of(wslot_r, wx_r);
        if (!walk_done_r) begin
          pend_nxt = !((wy_r == out_row_r) && (wx_r == out_col_r));
          if (wx_r == x1_r) begin
            if (wy_r == y1_r) begin
              walk_done_nxt = 1'b1;
            end else begin
              wx_nxt    = x0_r;
              wy_nxt    = wy_r + 16'd1;
              wslot_nxt = (wslot_r == SLOT_W'(RING_ROWS - 1)) ? '0 : wslot_r + 1'b1;
            end
          end else begin
            wx_nxt = wx_r + 1'b1;
          end
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_MULT;
          end
        end
      end
      S_MULT: begin
        if (mac_sw == '0) begin
          commit     = 1'b1;
          commit_pix = c_r;
        end else begin
          prod_nxt  = NUM_W'(c_inc) * NUM_W'(mac_sw);
          state_nxt = S_DLOAD;
        end
      end
      S_DLOAD: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          commit     = 1'b1;
          commit_pix = div_q;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // hold the finished output and step the output position
    if (commit) begin
      res_nxt.out_pixel    = commit_pix;
      res_nxt.end_of_line  = eol;
      res_nxt.end_of_frame = eof;
      res_nxt.rejected     = 1'b0;
      res_nxt.last_of_run  = 1'b0;
      hold_nxt             = 1'b1;
      n_nxt                = n_r + 1'b1;
      if (eol) begin
        out_col_nxt = '0;
        if (eof) begin
          out_row_nxt  = '0;
          out_slot_nxt = '0;
        end else begin
          out_row_nxt  = out_row_r + 16'd1;
          out_slot_nxt = (out_slot_r == SLOT_W'(RING_ROWS - 1)) ? '0 : out_slot_r + 1'b1;
        end
      end else begin
        out_col_nxt = out_col_r + 1'b1;
      end
      if (eof && !push_mode_r) begin
        draining_nxt = 1'b0;
      end
      state_nxt = S_CHECK;
    end

    // end of a push that completed the frame input
    if (finish && frame_pend_r) begin
      draining_nxt = 1'b1;
    end

    // register writes restart the frame
    if (cfg_we) begin
      case (cfg_addr)
        REG_IMAGE_WIDTH:  cfg_w_nxt  = cfg_wdata[10:0];
        REG_IMAGE_HEIGHT: cfg_h_nxt  = cfg_wdata[15:0];
        REG_HALF_X:       cfg_hx_nxt = cfg_wdata[1:0];
        REG_HALF_Y:       cfg_hy_nxt = cfg_wdata[1:0];
        default:          cfg_w_nxt  = cfg_w_r;
      endcase
      in_col_nxt   = '0;
      in_row_nxt   = '0;
      in_slot_nxt  = '0;
      out_col_nxt  = '0;
      out_row_nxt  = '0;
      out_slot_nxt = '0;
      draining_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cfg_w_r      <= 11'd1024;
      cfg_h_r      <= 16'd512;
      cfg_hx_r     <= 2'd1;
      cfg_hy_r     <= 2'd1;
      in_col_r     <= '0;
      in_row_r     <= '0;
      in_slot_r    <= '0;
      out_col_r    <= '0;
      out_row_r    <= '0;
      out_slot_r   <= '0;
      draining_r   <= 1'b0;
      frame_pend_r <= 1'b0;
      push_mode_r  <= 1'b0;
      n_r          <= '0;
      hold_r       <= 1'b0;
      last_r       <= 1'b0;
      walk_done_r  <= 1'b0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cfg_w_r      <= cfg_w_nxt;
      cfg_h_r      <= cfg_h_nxt;
      cfg_hx_r     <= cfg_hx_nxt;
      cfg_hy_r     <= cfg_hy_nxt;
      in_col_r     <= in_col_nxt;
      in_row_r     <= in_row_nxt;
      in_slot_r    <= in_slot_nxt;
      out_col_r    <= out_col_nxt;
      out_row_r    <= out_row_nxt;
      out_slot_r   <= out_slot_nxt;
      draining_r   <= draining_nxt;
      frame_pend_r <= frame_pend_nxt;
      push_mode_r  <= push_mode_nxt;
      n_r          <= n_nxt;
      hold_r       <= hold_nxt;
      last_r       <= last_nxt;
      walk_done_r  <= walk_done_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    pos_col_r  <= pos_col_nxt;
    pos_row_r  <= pos_row_nxt;
    res_r      <= res_nxt;
    c_r        <= c_nxt;
    wx_r       <= wx_nxt;
    wy_r       <= wy_nxt;
    wslot_r    <= wslot_nxt;
    x0_r       <= x0_nxt;
    x1_r       <= x1_nxt;
    y1_r       <= y1_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  // row ring
  gis_ram #(
    .WIDTH (PIX_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // weight and sum accumulator
  gis_mac #(
    .SW_W  (SW_W),
    .SWP_W (SWP_W)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .clr    (mac_clr),
    .en     (mac_en),
    .centre (c_r),
    .nbr    (ram_rdata),
    .sw     (mac_sw),
    .swp    (mac_swp)
  );

  // final divide
  gis_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .q     (div_q)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
